### src/natq_pkg.sv
// ----------------------------------------------------------------------------
// natq_pkg
// shared types, register indexes and reset constants for the nav/touch qualifier
// ----------------------------------------------------------------------------
`default_nettype none

package natq_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NUM_DIRS      = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STICK_THR   = 2'd0,
    REG_INIT_DELAY  = 2'd1,
    REG_REPEAT_IVL  = 2'd2,
    REG_DTAP_WINDOW = 2'd3
  } natq_reg_e;

  localparam logic [7:0]  STICK_THR_RST   = 8'd45;
  localparam logic [15:0] INIT_DELAY_RST  = 16'd400;
  localparam logic [15:0] REPEAT_IVL_RST  = 16'd120;
  localparam logic [15:0] DTAP_WINDOW_RST = 16'd250;

  // direction bit positions
  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  // touch unit results for one request
  typedef struct packed {
    logic       touch_active;
    logic       press_edge;
    logic       release_edge;
    logic       dbl_tap;
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic [8:0] prev_x;
    logic [7:0] prev_y;
  } natq_touch_res_t;

endpackage

`default_nettype wire

### src/natq_if.sv
// ----------------------------------------------------------------------------
// natq channel interfaces
// valid/ready channels for input frames and qualified results
// ----------------------------------------------------------------------------
`default_nettype none

interface natq_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        dpad_bits;
  logic signed [8:0] stick_x;
  logic signed [8:0] stick_y;
  logic              touch_held;
  logic [8:0]        touch_x_in;
  logic [7:0]        touch_y_in;
  logic [31:0]       time_ms;

  modport source (
    output valid, dpad_bits, stick_x, stick_y, touch_held, touch_x_in, touch_y_in,
           time_ms,
    input  ready
  );
  modport sink (
    input  valid, dpad_bits, stick_x, stick_y, touch_held, touch_x_in, touch_y_in,
           time_ms,
    output ready
  );
endinterface

interface natq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nav_fire;
  logic [3:0] nav_held;
  logic       touch_active;
  logic       touch_press_edge;
  logic       touch_release_edge;
  logic       dbl_tap;
  logic [8:0] touch_x_out;
  logic [7:0] touch_y_out;
  logic [8:0] prev_touch_x;
  logic [7:0] prev_touch_y;

  modport source (
    output valid, nav_fire, nav_held, touch_active, touch_press_edge,
           touch_release_edge, dbl_tap, touch_x_out, touch_y_out,
           prev_touch_x, prev_touch_y,
    input  ready
  );
  modport sink (
    input  valid, nav_fire, nav_held, touch_active, touch_press_edge,
           touch_release_edge, dbl_tap, touch_x_out, touch_y_out,
           prev_touch_x, prev_touch_y,
    output ready
  );
endinterface

`default_nettype wire

### src/natq_lane.sv
// ----------------------------------------------------------------------------
// natq_lane
// one direction: hold qualification, fresh-press fire and auto-repeat timing
// ----------------------------------------------------------------------------
`default_nettype none

module natq_lane #(
  parameter int TIME_BITS = natq_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 dpad_bit,
  input  wire logic signed [8:0]    axis,
  input  wire logic                 toward_neg,
  input  wire logic [7:0]           thr,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [15:0]          init_delay,
  input  wire logic [15:0]          repeat_ivl,
  output logic                      held,
  output logic                      fire
);
  import natq_pkg::*;

  logic                 was_r;
  logic [TIME_BITS-1:0] press_stamp_r;
  logic [TIME_BITS-1:0] last_rep_r;

  logic signed [9:0]    axis_w;
  logic signed [9:0]    thr_w;
  logic signed [9:0]    neg_thr_w;
  logic                 stick_hit;
  logic [TIME_BITS-1:0] since_start;
  logic [TIME_BITS-1:0] since_rep;
  logic                 repeat_due;

  always_comb begin
    axis_w    = {axis[8], axis};
    thr_w     = signed'({2'b00, thr});
    neg_thr_w = -thr_w;
    stick_hit = toward_neg ? (axis_w <= neg_thr_w) : (axis_w >= thr_w);
    held      = dpad_bit | stick_hit;
    // wrapping elapsed times
    since_start = now - press_stamp_r;
    since_rep   = now - last_rep_r;
    repeat_due  = (since_start >= TIME_BITS'(init_delay)) &&
                  (since_rep >= TIME_BITS'(repeat_ivl));
    fire        = held & (~was_r | repeat_due);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_r         <= 1'b0;
      press_stamp_r <= '0;
      last_rep_r    <= '0;
    end else if (en) begin
      was_r <= held;
      if (!held) begin
        press_stamp_r <= '0;
        last_rep_r    <= '0;
      end else if (!was_r) begin
        press_stamp_r <= now;
        last_rep_r    <= now;
      end else if (fire) begin
        last_rep_r <= now;
      end
    end
  end

endmodule

`default_nettype wire

### src/natq_touch.sv
// ----------------------------------------------------------------------------
// natq_touch
// touch edges, held position and double-tap detection
// ----------------------------------------------------------------------------
`default_nettype none

module natq_touch #(
  parameter int TIME_BITS = natq_pkg::TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   touch_held,
  input  wire logic [8:0]             touch_x,
  input  wire logic [7:0]             touch_y,
  input  wire logic [TIME_BITS-1:0]   now,
  input  wire logic [15:0]            dtap_window,
  output natq_pkg::natq_touch_res_t   res
);
  import natq_pkg::*;

  logic                 was_down_r;
  logic [8:0]           pos_x_r;
  logic [7:0]           pos_y_r;
  logic                 tap_pending_r;
  logic [TIME_BITS-1:0] last_tap_r;

  logic [TIME_BITS-1:0] since_tap;

  always_comb begin
    since_tap            = now - last_tap_r;
    res.touch_active     = touch_held;
    res.press_edge       = touch_held & ~was_down_r;
    res.release_edge     = ~touch_held & was_down_r;
    res.dbl_tap          = res.release_edge & tap_pending_r &
                           (since_tap <= TIME_BITS'(dtap_window));
    res.pos_x            = touch_held ? touch_x : pos_x_r;
    res.pos_y            = touch_held ? touch_y : pos_y_r;
    res.prev_x           = pos_x_r;
    res.prev_y           = pos_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r    <= 1'b0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      tap_pending_r <= 1'b0;
      last_tap_r    <= '0;
    end else if (en) begin
      was_down_r <= touch_held;
      pos_x_r    <= res.pos_x;
      pos_y_r    <= res.pos_y;
      if (res.release_edge) begin
        if (res.dbl_tap) begin
          tap_pending_r <= 1'b0;
        end else begin
          tap_pending_r <= 1'b1;
          last_tap_r    <= now;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/nav_autorepeat_touch_qualifier.sv
// ----------------------------------------------------------------------------
// nav_autorepeat_touch_qualifier: d-pad/stick auto-repeat and touch qualifier
// result valid in the cycle after request accept; 1 request per cycle while the sink is ready
// rate set by the single result register, which takes a new request as it drains
// synchronous active-low reset: registers to defaults, all timers and touch state zero
// ----------------------------------------------------------------------------
`default_nettype none

module nav_autorepeat_touch_qualifier #(
  parameter int TIME_BITS = natq_pkg::TIME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  natq_in_if.sink                               in_chan,
  natq_out_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [natq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [natq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import natq_pkg::*;

  // configuration registers
  logic [7:0]  stick_thr_r;
  logic [15:0] init_delay_r;
  logic [15:0] repeat_ivl_r;
  logic [15:0] dtap_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_thr_r   <= STICK_THR_RST;
      init_delay_r  <= INIT_DELAY_RST;
      repeat_ivl_r  <= REPEAT_IVL_RST;
      dtap_window_r <= DTAP_WINDOW_RST;
    end else if (cfg_we) begin
      case (natq_reg_e'(cfg_idx))
        REG_STICK_THR:   stick_thr_r   <= cfg_wdata[7:0];
        REG_INIT_DELAY:  init_delay_r  <= cfg_wdata;
        REG_REPEAT_IVL:  repeat_ivl_r  <= cfg_wdata;
        REG_DTAP_WINDOW: dtap_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request handshake: result register frees up as soon as the sink takes it
  logic out_valid_r;
  logic accept;

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  // time reduced to the counter width
  logic [TIME_BITS-1:0] now;
  assign now = TIME_BITS'(in_chan.time_ms);

  // one lane per direction, each with its own press/repeat timers
  logic [NUM_DIRS-1:0] lane_held;
  logic [NUM_DIRS-1:0] lane_fire;

  for (genvar d = 0; d < NUM_DIRS; d++) begin : g_lane
    // up/down follow the vertical axis, left/right the horizontal one
    localparam bit IS_VERT = (d == DIR_UP) || (d == DIR_DOWN);
    localparam bit IS_NEG  = (d == DIR_DOWN) || (d == DIR_LEFT);

    natq_lane #(.TIME_BITS(TIME_BITS)) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (accept),
      .dpad_bit   (in_chan.dpad_bits[d]),
      .axis       (IS_VERT ? in_chan.stick_y : in_chan.stick_x),
      .toward_neg (IS_NEG),
      .thr        (stick_thr_r),
      .now        (now),
      .init_delay (init_delay_r),
      .repeat_ivl (repeat_ivl_r),
      .held       (lane_held[d]),
      .fire       (lane_fire[d])
    );
  end

  // touch edges, position and double tap
  natq_touch_res_t touch_res;

  natq_touch #(.TIME_BITS(TIME_BITS)) u_touch (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (accept),
    .touch_held  (in_chan.touch_held),
    .touch_x     (in_chan.touch_x_in),
    .touch_y     (in_chan.touch_y_in),
    .now         (now),
    .dtap_window (dtap_window_r),
    .res         (touch_res)
  );

  // merge stage: lane bits gathered with the touch results into the result register
  logic [NUM_DIRS-1:0] nav_fire_r;
  logic [NUM_DIRS-1:0] nav_held_r;
  natq_touch_res_t     touch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept | (out_valid_r & ~out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nav_fire_r <= lane_fire;
      nav_held_r <= lane_held;
      touch_r    <= touch_res;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.nav_fire           = nav_fire_r;
  assign out_chan.nav_held           = nav_held_r;
  assign out_chan.touch_active       = touch_r.touch_active;
  assign out_chan.touch_press_edge   = touch_r.press_edge;
  assign out_chan.touch_release_edge = touch_r.release_edge;
  assign out_chan.dbl_tap            = touch_r.dbl_tap;
  assign out_chan.touch_x_out        = touch_r.pos_x;
  assign out_chan.touch_y_out        = touch_r.pos_y;
  assign out_chan.prev_touch_x       = touch_r.prev_x;
  assign out_chan.prev_touch_y       = touch_r.prev_y;

endmodule

`default_nettype wire

### src/natq_chk.sv
// ----------------------------------------------------------------------------
// natq_chk
// port-level checks on the qualifier's result channel
// ----------------------------------------------------------------------------
`default_nettype none

module natq_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] nav_fire,
  input wire logic [3:0] nav_held,
  input wire logic       touch_lvl,
  input wire logic       press_edge,
  input wire logic       release_edge,
  input wire logic       dbl_tap
);

  // a stalled result stays up
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a direction only fires while it is held
  a_fire_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((nav_fire & ~nav_held) == 4'd0))
    else $error("fire on a direction not held");

  // edges agree with the touch level
  a_touch_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!press_edge || touch_lvl) && (!release_edge || !touch_lvl))
    else $error("touch edge disagrees with touch level");

  // a double tap completes only on a release
  a_dtap_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dbl_tap |-> release_edge)
    else $error("double tap without release");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nav_autorepeat_touch_qualifier natq_chk u_natq_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .nav_fire     (out_chan.nav_fire),
  .nav_held     (out_chan.nav_held),
  .touch_lvl    (out_chan.touch_active),
  .press_edge   (out_chan.touch_press_edge),
  .release_edge (out_chan.touch_release_edge),
  .dbl_tap      (out_chan.dbl_tap)
);

`default_nettype wire

### bench/nav_autorepeat_touch_qualifier_tb.sv
// ----------------------------------------------------------------------------
// nav_autorepeat_touch_qualifier_tb
// drives frames into the nav/touch qualifier through the valid/ready channels,
// predicts every result in a scoreboard of its own and compares field by field
// while both channel ends idle at random outside one steady phase; covers several register settings
// ----------------------------------------------------------------------------
`default_nettype none

module nav_autorepeat_touch_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import natq_pkg::*;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int RANDOM_TOTAL = 1650;
  localparam int PHASES       = 6;

  // one input frame as the block sees it
  typedef struct {
    logic [3:0]        dpad;
    logic signed [8:0] sx;
    logic signed [8:0] sy;
    logic              touch;
    logic [8:0]        tx;
    logic [7:0]        ty;
    logic [31:0]       t;
  } frame_t;

  // one qualified result
  typedef struct {
    logic [3:0] fire;
    logic [3:0] held;
    logic       down;
    logic       press;
    logic       release_e;
    logic       dtap;
    logic [8:0] x;
    logic [7:0] y;
    logic [8:0] px;
    logic [7:0] py;
  } qual_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the registers and the qualifier state
  // --------------------------------------------------------------------------
  class nav_touch_scoreboard;
    logic [7:0]   thr;
    logic [15:0]  delay_ms;
    logic [15:0]  ivl_ms;
    logic [15:0]  window_ms;
    logic [3:0]   dirs_q;
    logic [31:0]  press_stamp [NUM_DIRS];
    logic [31:0]  last_fire [NUM_DIRS];
    logic         touch_q;
    logic [8:0]   pos_x;
    logic [7:0]   pos_y;
    logic         tap_armed;
    logic [31:0]  tap_stamp;
    qual_result_t expected_q [$];
    int           mismatches;

    function new();
      thr       = STICK_THR_RST;
      delay_ms  = INIT_DELAY_RST;
      ivl_ms    = REPEAT_IVL_RST;
      window_ms = DTAP_WINDOW_RST;
      dirs_q    = '0;
      for (int i = 0; i < NUM_DIRS; i++) begin
        press_stamp[i] = '0;
        last_fire[i]   = '0;
      end
      touch_q    = 1'b0;
      pos_x      = '0;
      pos_y      = '0;
      tap_armed  = 1'b0;
      tap_stamp  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(natq_reg_e idx, logic [15:0] v);
      case (idx)
        REG_STICK_THR:   thr       = v[7:0];
        REG_INIT_DELAY:  delay_ms  = v;
        REG_REPEAT_IVL:  ivl_ms    = v;
        REG_DTAP_WINDOW: window_ms = v;
        default: ;
      endcase
    endfunction

    // accepted request: work out the result it causes
    function void note_frame(frame_t f);
      int           sx;
      int           sy;
      int           th;
      logic [3:0]   held_now;
      logic [3:0]   fire;
      logic [31:0]  gap;
      qual_result_t r;
      sx = f.sx;
      sy = f.sy;
      th = thr;
      r.px = pos_x;
      r.py = pos_y;
      r.down      = f.touch;
      r.press     = f.touch && !touch_q;
      r.release_e = !f.touch && touch_q;
      r.dtap      = 1'b0;
      touch_q = f.touch;
      if (f.touch) begin
        pos_x = f.tx;
        pos_y = f.ty;
      end
      if (r.release_e) begin
        gap = f.t - tap_stamp;
        if (tap_armed && gap <= {16'h0, window_ms}) begin
          r.dtap    = 1'b1;
          tap_armed = 1'b0;
        end else begin
          tap_armed = 1'b1;
          tap_stamp = f.t;
        end
      end
      held_now = f.dpad;
      if (sy >= th)  held_now[DIR_UP]    = 1'b1;
      if (sy <= -th) held_now[DIR_DOWN]  = 1'b1;
      if (sx <= -th) held_now[DIR_LEFT]  = 1'b1;
      if (sx >= th)  held_now[DIR_RIGHT] = 1'b1;
      fire = '0;
      for (int i = 0; i < NUM_DIRS; i++) begin
        if (held_now[i] && !dirs_q[i]) begin
          fire[i]        = 1'b1;
          press_stamp[i] = f.t;
          last_fire[i]   = f.t;
        end else if (held_now[i]) begin
          if ((f.t - press_stamp[i]) >= {16'h0, delay_ms} &&
              (f.t - last_fire[i]) >= {16'h0, ivl_ms}) begin
            fire[i]      = 1'b1;
            last_fire[i] = f.t;
          end
        end else begin
          press_stamp[i] = '0;
          last_fire[i]   = '0;
        end
      end
      dirs_q = held_now;
      r.fire = fire;
      r.held = held_now;
      r.x    = pos_x;
      r.y    = pos_y;
      expected_q.push_back(r);
    endfunction

    function void flag_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0h actual %0h", what, want, got);
      end
    endfunction

    // accepted result: compare with the oldest expectation
    function void check_result(qual_result_t got);
      qual_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      flag_field("nav_fire", 32'(want.fire), 32'(got.fire));
      flag_field("nav_held", 32'(want.held), 32'(got.held));
      flag_field("touch_active", 32'(want.down), 32'(got.down));
      flag_field("touch_press_edge", 32'(want.press), 32'(got.press));
      flag_field("touch_release_edge", 32'(want.release_e), 32'(got.release_e));
      flag_field("dbl_tap", 32'(want.dtap), 32'(got.dtap));
      flag_field("touch_x_out", 32'(want.x), 32'(got.x));
      flag_field("touch_y_out", 32'(want.y), 32'(got.y));
      flag_field("prev_touch_x", 32'(want.px), 32'(got.px));
      flag_field("prev_touch_y", 32'(want.py), 32'(got.py));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  natq_reg_e   cfg_idx;
  logic [15:0] cfg_wdata;
  logic        steady;      // no idling on either side while set
  int          cycles;

  // random walk state for well-formed frame sequences
  logic [3:0]        walk_dpad;
  logic signed [8:0] walk_sx;
  logic signed [8:0] walk_sy;
  logic              walk_touch;
  logic [31:0]       walk_time;

  natq_in_if  in_chan ();
  natq_out_if out_chan ();

  nav_touch_scoreboard sb = new();

  nav_autorepeat_touch_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side drops ready at random, 28 percent of the time, unless steady
  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // handshake monitor: the request is noted before the result is checked so a
  // same-edge pair still lines up in order
  always @(posedge clk) begin
    frame_t       f;
    qual_result_t r;
    if (rst_n && in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
      f.dpad  = in_chan.dpad_bits;
      f.sx    = in_chan.stick_x;
      f.sy    = in_chan.stick_y;
      f.touch = in_chan.touch_held;
      f.tx    = in_chan.touch_x_in;
      f.ty    = in_chan.touch_y_in;
      f.t     = in_chan.time_ms;
      sb.note_frame(f);
    end
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      r.fire      = out_chan.nav_fire;
      r.held      = out_chan.nav_held;
      r.down      = out_chan.touch_active;
      r.press     = out_chan.touch_press_edge;
      r.release_e = out_chan.touch_release_edge;
      r.dtap      = out_chan.dbl_tap;
      r.x         = out_chan.touch_x_out;
      r.y         = out_chan.touch_y_out;
      r.px        = out_chan.prev_touch_x;
      r.py        = out_chan.prev_touch_y;
      sb.check_result(r);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // offer one request; returns at the edge where it was taken
  task automatic offer_frame(frame_t f);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.dpad_bits  <= f.dpad;
    in_chan.stick_x    <= f.sx;
    in_chan.stick_y    <= f.sy;
    in_chan.touch_held <= f.touch;
    in_chan.touch_x_in <= f.tx;
    in_chan.touch_y_in <= f.ty;
    in_chan.time_ms    <= f.t;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  // directed request from plain numbers
  task automatic frame_at(logic [3:0] d, int sx, int sy, logic th, int tx, int ty,
                          logic [31:0] t);
    frame_t f;
    f.dpad  = d;
    f.sx    = sx[8:0];
    f.sy    = sy[8:0];
    f.touch = th;
    f.tx    = tx[8:0];
    f.ty    = ty[7:0];
    f.t     = t;
    offer_frame(f);
  endtask

  // drop valid after the last request, wait out every result plus latency
  task automatic drain;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all four registers back to back, only while idle
  task automatic program_regs(logic [7:0] thr, logic [15:0] dly, logic [15:0] ivl,
                              logic [15:0] win);
    natq_reg_e   idx [4];
    logic [15:0] val [4];
    idx = '{REG_STICK_THR, REG_INIT_DELAY, REG_REPEAT_IVL, REG_DTAP_WINDOW};
    val = '{{8'h0, thr}, dly, ivl, win};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // stick value close to the current threshold, either sign
  function automatic logic signed [8:0] near_edge();
    int m;
    m = int'(sb.thr) + int'($urandom_range(0, 4)) - 2;
    if (m > 255) m = 255;
    if (m < 0) m = 0;
    return $urandom_range(0, 1) ? m[8:0] : -m[8:0];
  endfunction

  function automatic logic signed [8:0] pick_axis(logic signed [8:0] prev);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 4) return prev;
    if (mode <= 6) return near_edge();
    if (mode == 7) return '0;
    return 9'($urandom_range(0, 511));
  endfunction

  // next random frame: mostly slow walks of held keys, sticks and taps,
  // sometimes a jump in time or a burst of noise
  task automatic random_frame;
    frame_t f;
    if ($urandom_range(0, 99) < 3) walk_time = $urandom();
    else walk_time = walk_time + $urandom_range(0, 40);
    if ($urandom_range(0, 99) < 5) begin
      walk_dpad = 4'($urandom_range(0, 15));
    end else begin
      for (int i = 0; i < NUM_DIRS; i++)
        if ($urandom_range(0, 99) < 8) walk_dpad[i] = !walk_dpad[i];
    end
    walk_sx = pick_axis(walk_sx);
    walk_sy = pick_axis(walk_sy);
    if ($urandom_range(0, 99) < 15) walk_touch = !walk_touch;
    f.dpad  = walk_dpad;
    f.sx    = walk_sx;
    f.sy    = walk_sy;
    f.touch = walk_touch;
    // positions past the screen edge now and then, and junk while released
    if (walk_touch && $urandom_range(0, 99) < 85) begin
      f.tx = 9'($urandom_range(0, 319));
      f.ty = 8'($urandom_range(0, 239));
    end else begin
      f.tx = 9'($urandom_range(0, 511));
      f.ty = 8'($urandom_range(0, 255));
    end
    f.t = walk_time;
    offer_frame(f);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cycles             = 0;
    steady             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_STICK_THR;
    cfg_wdata          = '0;
    out_chan.ready     = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.dpad_bits  = '0;
    in_chan.stick_x    = '0;
    in_chan.stick_y    = '0;
    in_chan.touch_held = 1'b0;
    in_chan.touch_x_in = '0;
    in_chan.touch_y_in = '0;
    in_chan.time_ms    = '0;
    walk_dpad  = '0;
    walk_sx    = '0;
    walk_sy    = '0;
    walk_touch = 1'b0;
    walk_time  = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd0);
    // all four pressed, then initial delay and repeat interval
    frame_at(4'hF, 0, 0, 1'b0, 0, 0, 32'd10);
    frame_at(4'hF, 0, 0, 1'b0, 0, 0, 32'd300);
    frame_at(4'hF, 0, 0, 1'b0, 0, 0, 32'd420);
    frame_at(4'hF, 0, 0, 1'b0, 0, 0, 32'd500);
    frame_at(4'hF, 0, 0, 1'b0, 0, 0, 32'd540);
    // stick extremes take over down and right, then flip to up and left
    frame_at(4'h0, 255, -256, 1'b0, 0, 0, 32'd600);
    frame_at(4'h0, -256, 255, 1'b0, 0, 0, 32'd610);
    // exactly at the threshold, then one short of it
    frame_at(4'h0, 45, -45, 1'b0, 0, 0, 32'd620);
    frame_at(4'h0, 44, -44, 1'b0, 0, 0, 32'd630);
    // press at the screen corner, release arms a tap
    frame_at(4'h0, 0, 0, 1'b1, 319, 239, 32'd1000);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd1100);
    // out-of-range position, release inside the window gives a double tap
    frame_at(4'h0, 0, 0, 1'b1, 511, 255, 32'd1150);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd1200);
    // second pair just outside the window
    frame_at(4'h0, 0, 0, 1'b1, 12, 34, 32'd1300);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd1400);
    frame_at(4'h0, 0, 0, 1'b1, 100, 200, 32'd1500);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd1651);
    // hold across the time wrap
    frame_at(4'h1, 0, 0, 1'b0, 0, 0, 32'hFFFF_FF00);
    frame_at(4'h1, 0, 0, 1'b0, 0, 0, 32'h0000_0100);
    // tap pair across the time wrap
    frame_at(4'h0, 0, 0, 1'b1, 1, 2, 32'hFFFF_FFF0);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'hFFFF_FFF8);
    frame_at(4'h0, 0, 0, 1'b1, 3, 4, 32'h0000_0010);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'h0000_0020);
    drain();

    // zero threshold: a centered stick holds all four, zero delay repeats each frame
    program_regs(8'd0, 16'd0, 16'd0, 16'd0);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd2000);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd2000);
    frame_at(4'h0, 0, 0, 1'b0, 0, 0, 32'd2001);
    drain();

    // largest settings
    program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    frame_at(4'h0, -256, 255, 1'b0, 0, 0, 32'd3000);
    frame_at(4'h0, 255, -255, 1'b0, 0, 0, 32'd3010);
    frame_at(4'h0, 254, -254, 1'b0, 0, 0, 32'd3020);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 2, 5: program_regs(8'($urandom_range(20, 100)), 16'($urandom_range(0, 200)),
                              16'($urandom_range(0, 80)), 16'($urandom_range(50, 300)));
        1:       program_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        3:       program_regs(8'd0, 16'd0, 16'd0, 16'd0);
        default: program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      endcase
      walk_time = (p == 5) ? 32'hFFFF_FF00 : $urandom();
      steady    = (p == 2);   // one long stretch with no idling at all
      for (int n = 0; n < RANDOM_TOTAL / PHASES; n++) random_frame();
      drain();
      steady = 1'b0;
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
